[sv/assert_macros.svh]
//------------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL. Synthesis builds see empty
// bodies.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[sv/ilp_pkg.sv]
//------------------------------------------------------------------------------
// ilp_pkg
// Shared types and codes of the integer literal parser.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package ilp_pkg;

   localparam int VALUE_W = 64;
   localparam int BITS_W  = 7;
   localparam int STAT_W  = 3;

   // Status codes of a result word.
   localparam logic [STAT_W-1:0] ST_OK           = 3'd0;
   localparam logic [STAT_W-1:0] ST_NOT_INT      = 3'd1;
   localparam logic [STAT_W-1:0] ST_NEG_UNSIGNED = 3'd2;
   localparam logic [STAT_W-1:0] ST_MALFORMED    = 3'd3;
   localparam logic [STAT_W-1:0] ST_RANGE        = 3'd4;

   // One input word, unpacked.
   typedef struct packed {
      logic [7:0]        ch;
      logic              no_char;
      logic              last;
      logic              integer_type;
      logic              signed_type;
      logic [BITS_W-1:0] int_bits;
      logic              negative;
   } item_type;

   // Finished literal handed from the accumulator to the checker.
   typedef struct packed {
      logic [VALUE_W-1:0] magnitude;
      logic               digit_seen;
      logic               bad_char;
      logic               overflowed;
      logic               is_int;
      logic               signed_tgt;
      logic               neg;
      logic [VALUE_W-1:0] mask;
      logic [VALUE_W-1:0] limit;
   } fin_type;

   // One result word, unpacked.
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [STAT_W-1:0]  status;
   } result_type;

endpackage

[sv/integer_literal_parser_unit.sv]
//------------------------------------------------------------------------------
// integer_literal_parser_unit
// Parses an integer literal streamed one character per word into a value.
//------------------------------------------------------------------------------
//
//   channel  direction  word contents
//   req      in         one character plus target type fields; tlast ends it
//   rsp      out        one value and status per literal
//
// One word can be taken every cycle, except while a last word in the input
// register waits for room in the check stage. The accumulator folds each word
// from the input register into the literal state; a last word also loads the
// check stage, whose result is captured in the output register and offered on rsp.
// Synchronous reset clears every valid flag and the literal state. A stall on
// rsp backs up through the check stage; only last words wait for room there.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module integer_literal_parser_unit import ilp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // Input word stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] ch, [8] integer_type, [9] signed_type, [16:10] int_bits,
   // [17] negative, [23:18] zero.
   input  logic [23:0] req_tdata,
   // [0] no_char.
   input  logic        req_tuser,
   input  logic        req_tlast,
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [63:0] value, [66:64] status, [71:67] zero.
   output logic [71:0] rsp_tdata
);

   // Input register: one word, loaded whenever it is empty or draining.
   logic       in_vld_ff, in_vld_in;
   item_type   in_ff;
   item_type   req_item;

   // The check stage holds one finished literal; the output register one result.
   logic       fin_vld_ff, fin_vld_in;
   logic       out_vld_ff, out_vld_in;
   result_type out_ff;

   fin_type    fin;
   result_type result;

   logic       out_rdy;
   logic       fin_rdy;
   logic       fin_go;
   logic       in_go;
   logic       req_take;

   always_comb begin
      req_item.ch           = req_tdata[7:0];
      req_item.no_char      = req_tuser;
      req_item.last         = req_tlast;
      req_item.integer_type = req_tdata[8];
      req_item.signed_type  = req_tdata[9];
      req_item.int_bits     = req_tdata[16:10];
      req_item.negative     = req_tdata[17];
   end

   // Each stage advances when the one after it has room or is draining; non-last words need not wait.
   assign out_rdy    = !out_vld_ff || rsp_tready;
   assign fin_go     = fin_vld_ff && out_rdy;
   assign fin_rdy    = !fin_vld_ff || out_rdy;
   assign in_go      = in_vld_ff && (!in_ff.last || fin_rdy);
   assign req_tready = !in_vld_ff || in_go;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (in_go) begin
         in_vld_in = 1'b0;
      end

      fin_vld_in = fin_vld_ff;
      if (in_go && in_ff.last) begin
         fin_vld_in = 1'b1;
      end else if (fin_go) begin
         fin_vld_in = 1'b0;
      end

      out_vld_in = out_vld_ff;
      if (fin_go) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         fin_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         fin_vld_ff <= fin_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= req_item;
      end
      if (fin_go) begin
         out_ff <= result;
      end
   end

   ilp_accum u_accum (
      .clock (clock),
      .reset (reset),
      .step  (in_go),
      .item  (in_ff),
      .fin   (fin)
   );

   ilp_check u_check (
      .clock  (clock),
      .load   (in_go && in_ff.last),
      .fin    (fin),
      .result (result)
   );

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {5'd0, out_ff.status, out_ff.value};

   // A failed status never carries a value.
   `ASSERT_IMPLIES(a_fail_zero, clock, reset,
      out_vld_ff && (out_ff.status != ST_OK), out_ff.value == '0)
   // A finished literal always reaches the check stage.
   `ASSERT_NEXT(a_last_to_fin, clock, reset, in_go && in_ff.last, fin_vld_ff)
   // No result appears without a finished literal behind it.
   `ASSERT_NEXT(a_no_phantom, clock, reset, out_rdy && !fin_vld_ff, !out_vld_ff)
   // Non-last words never wait on the result side.
   `ASSERT_IMPLIES(a_free_flow, clock, reset, in_vld_ff && !in_ff.last, in_go)

endmodule

[sv/ilp_accum.sv]
//------------------------------------------------------------------------------
// ilp_accum
// Per-character state of the literal: radix prefix, magnitude, sticky flags.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module ilp_accum import ilp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     step,
   input  item_type item,
   output fin_type  fin
);

   localparam logic [1:0] RADIX_DEC = 2'd0;
   localparam logic [1:0] RADIX_HEX = 2'd1;
   localparam logic [1:0] RADIX_BIN = 2'd2;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_F  = 8'h66;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_F  = 8'h46;
   localparam logic [7:0] CH_LO_X  = 8'h78;
   localparam logic [7:0] CH_UP_X  = 8'h58;
   localparam logic [7:0] CH_LO_B  = 8'h62;
   localparam logic [7:0] CH_UP_B  = 8'h42;

   // Returns {valid, digit} for character c in the given radix.
   function automatic logic [4:0] digit_of(input logic [7:0] c, input logic [1:0] radix);
      logic [3:0] d;
      logic       ok;
      d  = 4'd0;
      ok = 1'b0;
      if (c inside {[CH_ZERO:CH_NINE]}) begin
         d  = 4'(c - CH_ZERO);
         ok = 1'b1;
      end else if (c inside {[CH_LO_A:CH_LO_F]}) begin
         d  = 4'(c - CH_LO_A + 8'd10);
         ok = 1'b1;
      end else if (c inside {[CH_UP_A:CH_UP_F]}) begin
         d  = 4'(c - CH_UP_A + 8'd10);
         ok = 1'b1;
      end
      case (radix)
         RADIX_HEX: ok = ok;
         RADIX_BIN: ok = ok && (d < 4'd2);
         default:   ok = ok && (d < 4'd10);
      endcase
      return {ok, d};
   endfunction

   logic [VALUE_W-1:0] mag_ff, mag_in;
   logic [1:0]         idx_ff, idx_in;
   logic               fz_ff, fz_in;
   logic [1:0]         radix_ff, radix_in;
   logic               seen_ff, seen_in;
   logic               bad_ff, bad_in;
   logic               ovf_ff, ovf_in;

   logic [4:0]         dig;
   logic [VALUE_W+3:0] prod;
   logic               is_prefix;
   logic [BITS_W-1:0]  nbits;
   logic [VALUE_W-1:0] mask;

   assign dig = digit_of(item.ch, radix_ff);

   always_comb begin
      case (radix_ff)
         RADIX_HEX: prod = {mag_ff, 4'd0} + {64'd0, dig[3:0]};
         RADIX_BIN: prod = {3'd0, mag_ff, 1'b0} + {64'd0, dig[3:0]};
         default:   prod = {1'b0, mag_ff, 3'd0} + {3'd0, mag_ff, 1'b0}
                           + {64'd0, dig[3:0]};
      endcase
   end

   assign is_prefix = (idx_ff == 2'd1) && fz_ff && (radix_ff == RADIX_DEC) &&
                      (item.ch == CH_LO_X || item.ch == CH_UP_X ||
                       item.ch == CH_LO_B || item.ch == CH_UP_B);

   always_comb begin
      mag_in   = mag_ff;
      idx_in   = idx_ff;
      fz_in    = fz_ff;
      radix_in = radix_ff;
      seen_in  = seen_ff;
      bad_in   = bad_ff;
      ovf_in   = ovf_ff;
      if (!item.no_char) begin
         if (is_prefix) begin
            radix_in = (item.ch == CH_LO_X || item.ch == CH_UP_X) ? RADIX_HEX : RADIX_BIN;
            mag_in   = '0;
            seen_in  = 1'b0;
            idx_in   = 2'd2;
         end else begin
            if (idx_ff == 2'd0 && item.ch == CH_ZERO) begin
               fz_in = 1'b1;
            end
            if (idx_ff != 2'd2) begin
               idx_in = idx_ff + 2'd1;
            end
            if (!dig[4]) begin
               bad_in = 1'b1;
            end else begin
               mag_in  = prod[VALUE_W-1:0];
               ovf_in  = ovf_ff | (|prod[VALUE_W+3:VALUE_W]);
               seen_in = 1'b1;
            end
         end
      end
   end

   // Target width, clamped to 1..64, and the masks that follow from it.
   always_comb begin
      if (item.int_bits == '0) begin
         nbits = 7'd1;
      end else if (item.int_bits > 7'd64) begin
         nbits = 7'd64;
      end else begin
         nbits = item.int_bits;
      end
   end

   assign mask = {VALUE_W{1'b1}} >> (7'd64 - nbits);

   always_comb begin
      fin.magnitude  = mag_in;
      fin.digit_seen = seen_in;
      fin.bad_char   = bad_in;
      fin.overflowed = ovf_in;
      fin.is_int     = item.integer_type;
      fin.signed_tgt = item.signed_type;
      fin.neg        = item.negative;
      fin.mask       = mask;
      if (item.signed_type) begin
         fin.limit = item.negative ? (mask >> 1) + 64'd1 : (mask >> 1);
      end else begin
         fin.limit = mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && item.last)) begin
         mag_ff   <= '0;
         idx_ff   <= 2'd0;
         fz_ff    <= 1'b0;
         radix_ff <= RADIX_DEC;
         seen_ff  <= 1'b0;
         bad_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
      end else if (step) begin
         mag_ff   <= mag_in;
         idx_ff   <= idx_in;
         fz_ff    <= fz_in;
         radix_ff <= radix_in;
         seen_ff  <= seen_in;
         bad_ff   <= bad_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

[sv/ilp_check.sv]
//------------------------------------------------------------------------------
// ilp_check
// Holds a finished literal and derives its status and two's-complement value.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module ilp_check import ilp_pkg::*; (
   input  logic       clock,
   input  logic       load,
   input  fin_type    fin,
   output result_type result
);

   fin_type fin_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         fin_ff <= fin;
      end
   end

   // Type checks first, then syntax, then range.
   always_comb begin
      result.value = '0;
      if (!fin_ff.is_int) begin
         result.status = ST_NOT_INT;
      end else if (fin_ff.neg && !fin_ff.signed_tgt) begin
         result.status = ST_NEG_UNSIGNED;
      end else if (!fin_ff.digit_seen || fin_ff.bad_char) begin
         result.status = ST_MALFORMED;
      end else if (fin_ff.overflowed || (fin_ff.magnitude > fin_ff.limit)) begin
         result.status = ST_RANGE;
      end else begin
         result.status = ST_OK;
         result.value  = (fin_ff.neg ? (64'd0 - fin_ff.magnitude) : fin_ff.magnitude)
                         & fin_ff.mask;
      end
   end

endmodule
